[hw/rtl/slcan_pkg.sv]
// ============================================================================
// slcan_pkg: shared constants and helpers for the serial-line CAN parser
// Line sizing, ASCII codes, result kinds, hex and reply-text lookups.
// ============================================================================
package slcan_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LINE_DEPTH    = LINE_CAPACITY - 1;
    localparam int FILL_W        = $clog2(LINE_CAPACITY);
    localparam int ADDR_W        = $clog2(LINE_DEPTH);

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_ACK = 8'h0D;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_1   = 8'h31;

    // command letters
    localparam logic [7:0] CMD_OPEN     = 8'h4F;  // O
    localparam logic [7:0] CMD_TX       = 8'h74;  // t
    localparam logic [7:0] CMD_CLOSE    = 8'h43;  // C
    localparam logic [7:0] CMD_SPEED    = 8'h53;  // S
    localparam logic [7:0] CMD_VERSION  = 8'h56;  // V
    localparam logic [7:0] CMD_VER_LONG = 8'h76;  // v
    localparam logic [7:0] CMD_SERIAL   = 8'h4E;  // N

    // transmit line layout
    localparam int         TX_LEN_POS  = 4;
    localparam int         TX_DATA_POS = 5;
    localparam int         MIN_TX_LINE = 5;
    localparam logic [3:0] MAX_LEN     = 4'd8;

    localparam int         TEXT_IDX_W = 3;
    localparam logic [TEXT_IDX_W-1:0] TEXT_LAST = 3'd5;

    typedef enum logic [1:0] {
        KIND_HOST_BYTE = 2'd0,
        KIND_TX_FRAME  = 2'd1,
        KIND_OPEN      = 2'd2
    } kind_t;

    // non-hex characters decode as zero
    function automatic logic [3:0] hex_val(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'h00;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30;
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            d = ch - 8'h37;
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            d = ch - 8'h57;
        end
        return d[3:0];
    endfunction

    // version / serial replies: <letter> 0 x 0 1 CR, x = 0 for serial, else 1
    function automatic logic [7:0] text_char(input logic [7:0] first,
                                             input logic [TEXT_IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = first;
            3'd1:    c = CH_0;
            3'd2:    c = (first == CMD_SERIAL) ? CH_0 : CH_1;
            3'd3:    c = CH_0;
            3'd4:    c = CH_1;
            default: c = CH_CR;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/slcan_command_parser.sv]
// ============================================================================
// slcan_command_parser: ASCII command line parser for a serial-line CAN link
// Buffers host characters, decodes a line on CR and emits host replies,
// frame transmit requests and open-channel requests.
// ============================================================================
//
// channel  dir  tvalid/tready  tuser            tdata / tlast
// -------  ---  -------------  ---------------  ------------------------------
// s_       in   request        cmd (0 char,     host_char, request_ok
//                              1 status)
// m_       out  request        kind             host_byte, frame_id,
//                                               frame_len, frame_data; tlast
//
// A host character is either buffered or dropped when it is taken. On
// CR the line is walked through the single read port of the line memory,
// one character per cycle; V/v/N replies go out one byte a cycle while
// the output register is free. The one shared hex decoder and the memory
// read port set this pace. Reset (aresetn low, synchronous) empties the
// line and clears the pending request; line memory contents are not
// cleared. The sequencer stalls while the output register is full and
// m_tready is low; s_tready is high only while the sequencer is idle.
// ============================================================================
module slcan_command_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [7:0] host_char, [8] request_ok
    input  logic                s_tuser,   // [0] cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [87:0]         m_tdata,   // [7:0] host_byte, [19:8] frame_id,
                                           // [23:20] frame_len, [87:24] frame_data
    output slcan_pkg::kind_t    m_tuser,   // [1:0] kind
    output logic                m_tlast
);
    import slcan_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,    // take characters / status requests
        ST_STATUS,  // answer a status request
        ST_OP,      // decode command letter
        ST_HEX,     // walk hex digits of a transmit line
        ST_FRAME,   // issue transmit request
        ST_TEXT     // send a fixed reply string
    } state_t;

    state_t                 state_reg, state_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FILL_W-1:0]      line_len_reg, line_len_next;
    logic                   pending_reg, pending_next;
    logic                   status_ok_reg, status_ok_next;
    logic [FILL_W-1:0]      pos_reg, pos_next;
    logic [FILL_W-1:0]      end_pos_reg, end_pos_next;
    logic [7:0]             text_first_reg, text_first_next;
    logic [TEXT_IDX_W-1:0]  text_idx_reg, text_idx_next;
    logic [11:0]            id_reg, id_next;
    logic [3:0]             len_reg, len_next;
    logic [63:0]            data_reg, data_next;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic [11:0]            out_id_reg, out_id_next;
    logic [3:0]             out_len_reg, out_len_next;
    logic [63:0]            out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    // line memory: one write port, one registered read port
    logic [7:0]             line_mem [LINE_DEPTH];
    logic                   mem_we;
    logic [FILL_W-1:0]      rd_pos;
    logic [7:0]             rdata_reg;
    logic                   rd_ok_reg;

    logic                   out_free;
    logic                   load_item;
    kind_t                  load_kind;
    logic [7:0]             load_byte;
    logic                   load_last;
    logic [3:0]             nib;
    logic [3:0]             len_clamped;
    logic [3:0]             data_k;
    logic [5:0]             data_shamt;
    logic                   hex_done;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[fill_reg[ADDR_W-1:0]] <= s_tdata[7:0];
        end
        rdata_reg <= line_mem[rd_pos[ADDR_W-1:0]];
        rd_ok_reg <= (rd_pos < line_len_reg);
    end

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    // positions past the end of the line read as zero digits
    assign nib         = hex_val(rd_ok_reg ? rdata_reg : 8'h00);
    assign len_clamped = (nib > MAX_LEN) ? MAX_LEN : nib;
    assign data_k      = 4'(pos_reg - FILL_W'(TX_DATA_POS));
    assign data_shamt  = 6'd60 - {data_k, 2'b00};

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        line_len_next   = line_len_reg;
        pending_next    = pending_reg;
        status_ok_next  = status_ok_reg;
        pos_next        = pos_reg;
        end_pos_next    = end_pos_reg;
        text_first_next = text_first_reg;
        text_idx_next   = text_idx_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        data_next       = data_reg;
        mem_we          = 1'b0;
        rd_pos          = '0;
        load_item       = 1'b0;
        load_kind       = KIND_HOST_BYTE;
        load_byte       = 8'h00;
        load_last       = 1'b1;
        hex_done        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        // status without a pending request is ignored
                        if (pending_reg) begin
                            status_ok_next = s_tdata[8];
                            state_next     = ST_STATUS;
                        end
                    end else if (s_tdata[7:0] == CH_CR) begin
                        if (fill_reg != '0) begin
                            line_len_next = fill_reg;
                            state_next    = ST_OP;
                        end
                        fill_next = '0;
                    end else if (s_tdata[7:0] != CH_LF &&
                                 fill_reg < FILL_W'(LINE_DEPTH)) begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    load_item    = 1'b1;
                    load_byte    = status_ok_reg ? CH_ACK : CH_BEL;
                    pending_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_OP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    unique case (rdata_reg)
                        CMD_OPEN: begin
                            load_item    = 1'b1;
                            load_kind    = KIND_OPEN;
                            pending_next = 1'b1;
                        end
                        CMD_TX: begin
                            if (line_len_reg < FILL_W'(MIN_TX_LINE)) begin
                                load_item = 1'b1;
                                load_byte = CH_BEL;
                            end else begin
                                id_next    = '0;
                                len_next   = '0;
                                data_next  = '0;
                                pos_next   = FILL_W'(1);
                                rd_pos     = FILL_W'(1);
                                state_next = ST_HEX;
                            end
                        end
                        CMD_CLOSE, CMD_SPEED: begin
                            load_item = 1'b1;
                            load_byte = CH_ACK;
                        end
                        CMD_VERSION, CMD_VER_LONG, CMD_SERIAL: begin
                            text_first_next = rdata_reg;
                            text_idx_next   = '0;
                            state_next      = ST_TEXT;
                        end
                        default: begin
                            load_item = 1'b1;
                            load_byte = CH_BEL;
                        end
                    endcase
                end
            end
            ST_HEX: begin
                // one digit per cycle through the shared decoder
                if (pos_reg < FILL_W'(TX_LEN_POS)) begin
                    id_next = {id_reg[7:0], nib};
                end else if (pos_reg == FILL_W'(TX_LEN_POS)) begin
                    len_next     = len_clamped;
                    end_pos_next = FILL_W'(TX_LEN_POS) + FILL_W'({len_clamped, 1'b0});
                    hex_done     = (len_clamped == 4'd0);
                end else begin
                    data_next = data_reg | ({60'b0, nib} << data_shamt);
                    hex_done  = (pos_reg == end_pos_reg);
                end
                if (hex_done) begin
                    state_next = ST_FRAME;
                end else begin
                    pos_next = pos_reg + FILL_W'(1);
                    rd_pos   = pos_reg + FILL_W'(1);
                end
            end
            ST_FRAME: begin
                if (out_free) begin
                    load_item    = 1'b1;
                    load_kind    = KIND_TX_FRAME;
                    pending_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TEXT: begin
                if (out_free) begin
                    load_item     = 1'b1;
                    load_byte     = text_char(text_first_reg, text_idx_reg);
                    load_last     = (text_idx_reg == TEXT_LAST);
                    text_idx_next = text_idx_reg + TEXT_IDX_W'(1);
                    if (load_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output register
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_id_next    = out_id_reg;
        out_len_next   = out_len_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load_item) begin
            out_valid_next = 1'b1;
            out_kind_next  = load_kind;
            out_byte_next  = load_byte;
            out_last_next  = load_last;
            out_id_next    = (load_kind == KIND_TX_FRAME) ? id_reg   : 12'h000;
            out_len_next   = (load_kind == KIND_TX_FRAME) ? len_reg  : 4'h0;
            out_data_next  = (load_kind == KIND_TX_FRAME) ? data_reg : 64'h0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
        line_len_reg   <= line_len_next;
        status_ok_reg  <= status_ok_next;
        pos_reg        <= pos_next;
        end_pos_reg    <= end_pos_next;
        text_first_reg <= text_first_next;
        text_idx_reg   <= text_idx_next;
        id_reg         <= id_next;
        len_reg        <= len_next;
        data_reg       <= data_next;
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_id_reg     <= out_id_next;
        out_len_reg    <= out_len_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg, out_len_reg, out_id_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
